// ----- rtl/core/i2cds_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cds_pkg: bus clock divider selection package
// Field widths, reset value of the clock register and the divider table.
// ----------------------------------------------------------------------------
package i2cds_pkg;

   localparam int RATE_W    = 25;
   localparam int CLK_W     = 27;
   localparam int CODE_W    = 6;
   localparam int DIV_W     = 12;
   localparam int DIVIDEND_W = 28;
   localparam int TABLE_LEN = 50;
   localparam int IDX_W     = 6;

   localparam logic [CLK_W-1:0] CLK_RESET = CLK_W'(24000000);

   typedef logic [IDX_W-1:0] idx_type;

   // divider value of each table entry, ascending
   function automatic logic [DIV_W-1:0] div_at(input idx_type idx);
      logic [DIV_W-1:0] d;
      case (idx)
         6'd0:  d = 12'd22;   6'd1:  d = 12'd24;   6'd2:  d = 12'd26;
         6'd3:  d = 12'd28;   6'd4:  d = 12'd30;   6'd5:  d = 12'd32;
         6'd6:  d = 12'd36;   6'd7:  d = 12'd40;   6'd8:  d = 12'd42;
         6'd9:  d = 12'd44;   6'd10: d = 12'd48;   6'd11: d = 12'd52;
         6'd12: d = 12'd56;   6'd13: d = 12'd60;   6'd14: d = 12'd64;
         6'd15: d = 12'd72;   6'd16: d = 12'd80;   6'd17: d = 12'd88;
         6'd18: d = 12'd96;   6'd19: d = 12'd104;  6'd20: d = 12'd112;
         6'd21: d = 12'd128;  6'd22: d = 12'd144;  6'd23: d = 12'd160;
         6'd24: d = 12'd192;  6'd25: d = 12'd224;  6'd26: d = 12'd240;
         6'd27: d = 12'd256;  6'd28: d = 12'd288;  6'd29: d = 12'd320;
         6'd30: d = 12'd384;  6'd31: d = 12'd448;  6'd32: d = 12'd480;
         6'd33: d = 12'd512;  6'd34: d = 12'd576;  6'd35: d = 12'd640;
         6'd36: d = 12'd768;  6'd37: d = 12'd896;  6'd38: d = 12'd960;
         6'd39: d = 12'd1024; 6'd40: d = 12'd1152; 6'd41: d = 12'd1280;
         6'd42: d = 12'd1536; 6'd43: d = 12'd1792; 6'd44: d = 12'd1920;
         6'd45: d = 12'd2048; 6'd46: d = 12'd2304; 6'd47: d = 12'd2560;
         6'd48: d = 12'd3072; 6'd49: d = 12'd3840;
         default: d = 12'd3840;
      endcase
      return d;
   endfunction

   // register code paired with each table entry
   function automatic logic [CODE_W-1:0] code_at(input idx_type idx);
      logic [CODE_W-1:0] c;
      case (idx)
         6'd0:  c = 6'h20; 6'd1:  c = 6'h21; 6'd2:  c = 6'h22; 6'd3:  c = 6'h23;
         6'd4:  c = 6'h00; 6'd5:  c = 6'h24; 6'd6:  c = 6'h25; 6'd7:  c = 6'h26;
         6'd8:  c = 6'h03; 6'd9:  c = 6'h27; 6'd10: c = 6'h28; 6'd11: c = 6'h05;
         6'd12: c = 6'h29; 6'd13: c = 6'h06; 6'd14: c = 6'h2A; 6'd15: c = 6'h2B;
         6'd16: c = 6'h2C; 6'd17: c = 6'h09; 6'd18: c = 6'h2D; 6'd19: c = 6'h0A;
         6'd20: c = 6'h2E; 6'd21: c = 6'h2F; 6'd22: c = 6'h0C; 6'd23: c = 6'h30;
         6'd24: c = 6'h31; 6'd25: c = 6'h32; 6'd26: c = 6'h0F; 6'd27: c = 6'h33;
         6'd28: c = 6'h10; 6'd29: c = 6'h34; 6'd30: c = 6'h35; 6'd31: c = 6'h36;
         6'd32: c = 6'h13; 6'd33: c = 6'h37; 6'd34: c = 6'h14; 6'd35: c = 6'h38;
         6'd36: c = 6'h39; 6'd37: c = 6'h3A; 6'd38: c = 6'h17; 6'd39: c = 6'h3B;
         6'd40: c = 6'h18; 6'd41: c = 6'h3C; 6'd42: c = 6'h3D; 6'd43: c = 6'h3E;
         6'd44: c = 6'h1B; 6'd45: c = 6'h3F; 6'd46: c = 6'h1C; 6'd47: c = 6'h1D;
         6'd48: c = 6'h1E; 6'd49: c = 6'h1F;
         default: c = 6'h1F;
      endcase
      return c;
   endfunction

endpackage

// ----- rtl/core/i2c_clock_divider_select_unit.sv -----
`timescale 1ns / 1ps
// Sequence: a non-zero rate is taken through bit-serial division of the 28-bit
//   dividend, then a scan of one table entry per cycle; a zero rate goes
//   straight to the done state as an error item.
// Throughput: one item at a time; the next item is taken as soon as the result
//   moves into the output register, even while that result is still stalled.
// Reset: synchronous; clears control state and loads the clock register with 24 MHz.
// ----------------------------------------------------------------------------
// i2c_clock_divider_select_unit: bus clock divider selection
// Divides the source clock by the requested rate (rounding up) one quotient
// bit per cycle, then scans the divider table for the first entry that fits.
// ----------------------------------------------------------------------------
module i2c_clock_divider_select_unit
   import i2cds_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic [CLK_W-1:0]  csr_wr_data,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [RATE_W-1:0] req_bus_rate,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [CODE_W-1:0] rsp_divider_code,
   output logic [DIV_W-1:0]  rsp_chosen_divider,
   output logic              rsp_rate_error
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_DIVIDE = 2'd1;
   localparam logic [1:0] ST_SEARCH = 2'd2;
   localparam logic [1:0] ST_DONE   = 2'd3;

   localparam idx_type LAST_STEP  = IDX_W'(DIVIDEND_W - 1);
   localparam idx_type LAST_ENTRY = IDX_W'(TABLE_LEN - 1);

   logic [1:0]            state_ff, state_in;
   idx_type               cnt_ff, cnt_in;
   logic [CLK_W-1:0]      clk_hz_ff;
   logic [RATE_W-1:0]     rate_ff, rate_in;
   logic [RATE_W-1:0]     rem_ff, rem_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [CODE_W-1:0]     res_code_ff, res_code_in;
   logic [DIV_W-1:0]      res_div_ff, res_div_in;
   logic                  res_err_ff, res_err_in;
   logic                  out_valid_ff, out_valid_in;
   logic [CODE_W-1:0]     out_code_ff, out_code_in;
   logic [DIV_W-1:0]      out_div_ff, out_div_in;
   logic                  out_err_ff, out_err_in;

   logic                  req_take;
   logic                  out_free;
   logic [RATE_W:0]       trial;
   logic [RATE_W-1:0]     diff;
   logic                  q_bit;
   logic                  over;
   logic                  hit;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign out_free  = !out_valid_ff || !rsp_stall;

   // one restoring division step: bring down the next dividend bit
   assign trial = {rem_ff, quo_ff[DIVIDEND_W-1]};
   assign diff  = trial[RATE_W-1:0] - rate_ff;
   assign q_bit = (trial >= {1'b0, rate_ff});

   // quotient beyond the table range only matches the clamped last entry
   assign over = |quo_ff[DIVIDEND_W-1:DIV_W];
   assign hit  = !over && (quo_ff[DIV_W-1:0] <= div_at(cnt_ff));

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rate_in      = rate_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      res_code_in  = res_code_ff;
      res_div_in   = res_div_ff;
      res_err_in   = res_err_ff;
      out_valid_in = out_valid_ff;
      out_code_in  = out_code_ff;
      out_div_in   = out_div_ff;
      out_err_in   = out_err_ff;

      if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               rate_in = req_bus_rate;
               rem_in  = '0;
               cnt_in  = '0;
               quo_in  = DIVIDEND_W'({1'b0, clk_hz_ff} + DIVIDEND_W'(req_bus_rate)
                                     - DIVIDEND_W'(1));
               if (req_bus_rate == '0) begin
                  res_code_in = '0;
                  res_div_in  = '0;
                  res_err_in  = 1'b1;
                  state_in    = ST_DONE;
               end else begin
                  state_in = ST_DIVIDE;
               end
            end
         end
         ST_DIVIDE: begin
            rem_in = q_bit ? diff : trial[RATE_W-1:0];
            quo_in = {quo_ff[DIVIDEND_W-2:0], q_bit};
            if (cnt_ff == LAST_STEP) begin
               cnt_in   = '0;
               state_in = ST_SEARCH;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_SEARCH: begin
            if (hit || cnt_ff == LAST_ENTRY) begin
               res_code_in = code_at(cnt_ff);
               res_div_in  = div_at(cnt_ff);
               res_err_in  = 1'b0;
               state_in    = ST_DONE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_DONE: begin
            // hold until the output register can take the item
            if (out_free) begin
               out_valid_in = 1'b1;
               out_code_in  = res_code_ff;
               out_div_in   = res_div_ff;
               out_err_in   = res_err_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
         clk_hz_ff    <= CLK_RESET;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         out_valid_ff <= out_valid_in;
         if (csr_wr_en) begin
            clk_hz_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      rate_ff     <= rate_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      res_code_ff <= res_code_in;
      res_div_ff  <= res_div_in;
      res_err_ff  <= res_err_in;
      out_code_ff <= out_code_in;
      out_div_ff  <= out_div_in;
      out_err_ff  <= out_err_in;
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_divider_code   = out_code_ff;
   assign rsp_chosen_divider = out_div_ff;
   assign rsp_rate_error     = out_err_ff;

endmodule

// ----- rtl/core/i2cds_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cds_checker: port checks for the divider selection unit
// Watches the ports over time; attached to the top level by a bind.
// ----------------------------------------------------------------------------
module i2cds_checker
   import i2cds_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input logic [CODE_W-1:0] rsp_divider_code,
   input logic [DIV_W-1:0]  rsp_chosen_divider,
   input logic              rsp_rate_error
);

   // a stalled result item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_divider_code)
         && $stable(rsp_chosen_divider) && $stable(rsp_rate_error))
      else $error("stalled result item changed");

   // an error item carries zero code and divider
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_rate_error |-> rsp_divider_code == '0
         && rsp_chosen_divider == '0)
      else $error("error item with non-zero fields");

   // a good item always carries a divider within the table's range
   a_div_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_rate_error |-> rsp_chosen_divider >= DIV_W'(22)
         && rsp_chosen_divider <= DIV_W'(3840))
      else $error("chosen divider outside the table");

   // busy straight after taking an item
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input not stalled after accept");

endmodule

bind i2c_clock_divider_select_unit i2cds_checker u_i2cds_checker (.*);

// ----- dv/tb_i2c_clock_divider_select_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_i2c_clock_divider_select_unit: bus clock divider selection testbench
// Drives requested bus rates under several source clock settings and handshake
// profiles, predicts the selected table entry for each accepted item and
// checks every result against it in order.
// ----------------------------------------------------------------------------
module tb_i2c_clock_divider_select_unit;
   import i2cds_pkg::*;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int PHASE_ITEMS    = 250;
   localparam int SETTLE_CYCLES  = 90;

   localparam logic [DIV_W-1:0] DIV_LIST [TABLE_LEN] = '{
      12'd22,   12'd24,   12'd26,   12'd28,   12'd30,   12'd32,   12'd36,   12'd40,
      12'd42,   12'd44,   12'd48,   12'd52,   12'd56,   12'd60,   12'd64,   12'd72,
      12'd80,   12'd88,   12'd96,   12'd104,  12'd112,  12'd128,  12'd144,  12'd160,
      12'd192,  12'd224,  12'd240,  12'd256,  12'd288,  12'd320,  12'd384,  12'd448,
      12'd480,  12'd512,  12'd576,  12'd640,  12'd768,  12'd896,  12'd960,  12'd1024,
      12'd1152, 12'd1280, 12'd1536, 12'd1792, 12'd1920, 12'd2048, 12'd2304, 12'd2560,
      12'd3072, 12'd3840
   };

   localparam logic [CODE_W-1:0] CODE_LIST [TABLE_LEN] = '{
      6'h20, 6'h21, 6'h22, 6'h23, 6'h00, 6'h24, 6'h25, 6'h26, 6'h03, 6'h27,
      6'h28, 6'h05, 6'h29, 6'h06, 6'h2A, 6'h2B, 6'h2C, 6'h09, 6'h2D, 6'h0A,
      6'h2E, 6'h2F, 6'h0C, 6'h30, 6'h31, 6'h32, 6'h0F, 6'h33, 6'h10, 6'h34,
      6'h35, 6'h36, 6'h13, 6'h37, 6'h14, 6'h38, 6'h39, 6'h3A, 6'h17, 6'h3B,
      6'h18, 6'h3C, 6'h3D, 6'h3E, 6'h1B, 6'h3F, 6'h1C, 6'h1D, 6'h1E, 6'h1F
   };

   typedef struct packed {
      logic [CODE_W-1:0] code;
      logic [DIV_W-1:0]  divider;
      logic              rate_err;
   } selection_type;

   class divider_scoreboard;
      logic [CLK_W-1:0] clock_hz;
      selection_type    selection_q[$];
      int               errors;
      int               rates_seen;
      int               zero_rates;

      function new();
         clock_hz   = CLK_RESET;
         errors     = 0;
         rates_seen = 0;
         zero_rates = 0;
      endfunction

      function void set_clock(input logic [CLK_W-1:0] hz);
         clock_hz = hz;
      endfunction

      function selection_type select_entry(input logic [RATE_W-1:0] rate);
         selection_type sel;
         logic [63:0]   quot;
         int            idx;
         if (rate == '0) begin
            sel.code     = '0;
            sel.divider  = '0;
            sel.rate_err = 1'b1;
            return sel;
         end
         quot = (64'(clock_hz) + 64'(rate) - 64'd1) / 64'(rate);
         // scan downwards so the lowest fitting entry wins; clamp to the last
         idx = TABLE_LEN - 1;
         for (int k = TABLE_LEN - 1; k >= 0; k--) begin
            if (quot <= 64'(DIV_LIST[k])) idx = k;
         end
         sel.code     = CODE_LIST[idx];
         sel.divider  = DIV_LIST[idx];
         sel.rate_err = 1'b0;
         return sel;
      endfunction

      function void note_rate(input logic [RATE_W-1:0] rate);
         rates_seen++;
         if (rate == '0) zero_rates++;
         selection_q.push_back(select_entry(rate));
      endfunction

      function void check_result(input logic [CODE_W-1:0] code,
                                 input logic [DIV_W-1:0] divider,
                                 input logic rate_err);
         selection_type want;
         if (selection_q.size() == 0) begin
            $error("unexpected result: code %0h divider %0d rate_error %0b",
                   code, divider, rate_err);
            errors++;
            return;
         end
         want = selection_q.pop_front();
         if (code !== want.code) begin
            $error("divider_code: expected %0h, got %0h", want.code, code);
            errors++;
         end
         if (divider !== want.divider) begin
            $error("chosen_divider: expected %0d, got %0d", want.divider, divider);
            errors++;
         end
         if (rate_err !== want.rate_err) begin
            $error("rate_error: expected %0b, got %0b", want.rate_err, rate_err);
            errors++;
         end
      endfunction

      function int pending();
         return selection_q.size();
      endfunction
   endclass

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              csr_wr_en = 1'b0;
   logic [CLK_W-1:0]  csr_wr_data = '0;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [RATE_W-1:0] req_bus_rate = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [CODE_W-1:0] rsp_divider_code;
   logic [DIV_W-1:0]  rsp_chosen_divider;
   logic              rsp_rate_error;

   divider_scoreboard sb = new();
   int                idle_pct = 0;
   int                stall_pct = 0;
   int                quiet_cycles = 0;
   int                clock_settings = 1;

   i2c_clock_divider_select_unit i_dut (
      .clock              (clock),
      .reset              (reset),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_bus_rate       (req_bus_rate),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_divider_code   (rsp_divider_code),
      .rsp_chosen_divider (rsp_chosen_divider),
      .rsp_rate_error     (rsp_rate_error)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // note accepted items, check results and watch for a hang
   always @(posedge clock) begin
      if (req_valid && !req_stall) sb.note_rate(req_bus_rate);
      if (rsp_valid && !rsp_stall)
         sb.check_result(rsp_divider_code, rsp_chosen_divider, rsp_rate_error);
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
         $display("DONE: errors detected");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic write_clock(input logic [CLK_W-1:0] hz);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= hz;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      sb.set_clock(hz);
      clock_settings++;
   endtask

   // present one rate and hold it until taken; valid stays up between items unless an idle gap is drawn
   task automatic push_rate(input logic [RATE_W-1:0] rate);
      if ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < idle_pct) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_bus_rate <= rate;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // step one edge first so the last accepted item is already noted
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [RATE_W-1:0] pick_rate(input logic [CLK_W-1:0] hz);
      logic [63:0] base;
      logic [63:0] r;
      int          idx;
      case ($urandom_range(9))
         0: r = 64'd0;
         1: r = 64'($urandom);
         2: r = 64'($urandom_range(100, 1));
         3: r = 64'(hz) + 64'($urandom_range(1000));
         default: begin
            // land around a table boundary for the current clock
            idx  = $urandom_range(TABLE_LEN - 1);
            base = 64'(hz) / 64'(DIV_LIST[idx]);
            r    = base + 64'($urandom_range(2));
            if (r > 64'd1) r = r - 64'd1;
         end
      endcase
      return r[RATE_W-1:0];
   endfunction

   initial begin
      logic [CLK_W-1:0] phase_clock [8];
      phase_clock[0] = CLK_RESET;
      phase_clock[1] = CLK_W'(100000000);
      phase_clock[2] = CLK_W'(1);
      phase_clock[3] = '0;
      phase_clock[4] = '1;
      phase_clock[5] = CLK_W'(400000);
      phase_clock[6] = CLK_W'($urandom_range(100000000, 1));
      phase_clock[7] = CLK_W'($urandom_range(100000000, 1));

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: field extremes and the clamping edges at the reset clock
      push_rate('0);
      push_rate(RATE_W'(1));
      push_rate('1);
      push_rate(RATE_W'(24000000));
      push_rate(RATE_W'(1090910));
      push_rate(RATE_W'(1090909));
      push_rate(RATE_W'(6250));
      push_rate(RATE_W'(6249));
      push_rate(RATE_W'(100000));
      push_rate(RATE_W'(400000));
      push_rate(RATE_W'(12000000));
      push_rate(RATE_W'(800000));
      push_rate(RATE_W'(11718));
      push_rate(RATE_W'(11719));
      drain();

      for (int ph = 0; ph < 8; ph++) begin
         if (ph != 0) write_clock(phase_clock[ph]);
         case (ph % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 58; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 58; end
            default: begin idle_pct = 9; stall_pct = 9; end
         endcase
         push_rate('0);
         push_rate('1);
         push_rate(RATE_W'(1));
         for (int n = 0; n < PHASE_ITEMS; n++) push_rate(pick_rate(phase_clock[ph]));
         drain();
      end

      $display("covered %0d rates (%0d of them zero) across %0d source clock settings,",
               sb.rates_seen, sb.zero_rates, clock_settings);
      $display("with free-running, sender-idle, receiver-stall and mixed handshakes");
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// ----- files.f -----
rtl/core/i2cds_pkg.sv
rtl/core/i2c_clock_divider_select_unit.sv
rtl/core/i2cds_checker.sv
dv/tb_i2c_clock_divider_select_unit.sv
